>>> design/bsa_pkg.sv
`default_nettype none

package bsa_pkg;

  typedef enum logic [2:0] {
    ST_GRANTED      = 3'd0,
    ST_NONE_FREE    = 3'd1,
    ST_RELEASED     = 3'd2,
    ST_OUT_OF_RANGE = 3'd3,
    ST_ALREADY_FREE = 3'd4
  } bsa_status_t;

  typedef enum logic {
    OP_ACQUIRE = 1'b0,
    OP_RELEASE = 1'b1
  } bsa_op_t;

  typedef enum logic {
    REG_NUM_SLOTS = 1'b0,
    REG_SLOT_SIZE = 1'b1
  } bsa_reg_t;

  localparam int unsigned CNT_W    = 6;
  localparam int unsigned SIZE_W   = 17;
  localparam int unsigned OFS_W    = 21;
  localparam int unsigned FAIL_W   = 16;
  localparam int unsigned SLOT_W   = 5;
  localparam int unsigned ADDR_W   = 3;
  localparam int unsigned DATA_W   = 32;

  localparam logic [SIZE_W-1:0] SIZE_MAX   = 17'd65536;
  localparam logic [SIZE_W-1:0] SIZE_RESET = 17'd512;
  localparam logic [FAIL_W-1:0] FAIL_MAX   = 16'hFFFF;

  typedef struct packed {
    logic              operation;
    logic [SLOT_W-1:0] slot_index;
  } bsa_in_t;

  typedef struct packed {
    logic [2:0]        status;
    logic [SLOT_W-1:0] slot_number;
    logic [OFS_W-1:0]  byte_offset;
    logic [CNT_W-1:0]  slots_in_use;
    logic [CNT_W-1:0]  peak_in_use;
    logic [FAIL_W-1:0] failed_acquires;
  } bsa_out_t;

endpackage

`default_nettype wire

>>> design/bsa_if.sv
`default_nettype none

interface bsa_in_if;
  logic             valid;
  logic             ready;
  bsa_pkg::bsa_in_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface bsa_out_if;
  logic              valid;
  logic              ready;
  bsa_pkg::bsa_out_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

>>> design/bitmap_slot_allocator.sv
`default_nettype none

// Channel   Dir  Handshake       Payload
// in_ch     in   valid/ready     operation, slot_index
// out_ch    out  valid/ready     status, slot_number, byte_offset, slots_in_use,
//                                peak_in_use, failed_acquires
// cfg       in   APB write/read  num_slots @ 0x0, slot_size_bytes @ 0x4
//
// One item per cycle while the result is not held; the result passes through the
// input register, then the result register. The free bitmap priority encode and
// update are combinational, so each item sees the state left by the one before it.
// rst_n is synchronous: valids drop, all slots free, counters cleared.
// A held result stalls the input register; in_ch.ready falls only when both
// registers are full and out_ch.ready is low.
module bitmap_slot_allocator #(
  parameter int unsigned MAX_SLOTS = 32
) (
  input  wire                            clk,
  input  wire                            rst_n,
  bsa_in_if.sink                         in_ch,
  bsa_out_if.source                      out_ch,
  input  wire                            psel,
  input  wire                            penable,
  input  wire                            pwrite,
  input  wire  [bsa_pkg::ADDR_W-1:0]     paddr,
  input  wire  [bsa_pkg::DATA_W-1:0]     pwdata,
  output logic [bsa_pkg::DATA_W-1:0]     prdata,
  output logic                           pready
);

  localparam logic [bsa_pkg::CNT_W-1:0] CNT_MAX = bsa_pkg::CNT_W'(MAX_SLOTS);

  logic [bsa_pkg::CNT_W-1:0]  cnt_r;
  logic [bsa_pkg::SIZE_W-1:0] size_r;
  logic [MAX_SLOTS-1:0]       free_r;
  logic [bsa_pkg::CNT_W-1:0]  busy_r;
  logic [bsa_pkg::CNT_W-1:0]  peak_r;
  logic [bsa_pkg::FAIL_W-1:0] fail_r;

  logic                       a_vld_r;
  bsa_pkg::bsa_in_t           a_item_r;
  logic                       out_vld_r;
  bsa_pkg::bsa_out_t          out_item_r;

  logic                       b_free;
  logic                       a_adv;
  logic                       in_fire;
  logic                       cfg_wr;

  logic [bsa_pkg::CNT_W-1:0]  wcnt;
  logic [bsa_pkg::SIZE_W-1:0] wsize;
  logic [bsa_pkg::CNT_W-1:0]  cnt_nxt;
  logic [bsa_pkg::SIZE_W-1:0] size_nxt;
  logic [MAX_SLOTS-1:0]       rebuild_map;

  logic                       grant_hit;
  logic [bsa_pkg::SLOT_W-1:0] grant_slot;
  logic [MAX_SLOTS-1:0]       grant_mask;
  logic [MAX_SLOTS-1:0]       rel_mask;
  logic                       rel_in_range;
  logic                       rel_busy;
  logic [bsa_pkg::OFS_W-1:0]  grant_ofs;

  logic [MAX_SLOTS-1:0]       free_nxt;
  logic [bsa_pkg::CNT_W-1:0]  busy_nxt;
  logic [bsa_pkg::CNT_W-1:0]  peak_nxt;
  logic [bsa_pkg::FAIL_W-1:0] fail_nxt;
  bsa_pkg::bsa_out_t          res_nxt;

  assign b_free  = !out_vld_r || out_ch.ready;
  assign a_adv   = a_vld_r && b_free;
  assign in_fire = in_ch.valid && in_ch.ready;
  assign cfg_wr  = psel && penable && pwrite;

  assign in_ch.ready    = !a_vld_r || b_free;
  assign out_ch.valid   = out_vld_r;
  assign out_ch.payload = out_item_r;

  assign pready = 1'b1;

  always_comb begin
    if (paddr[2] == bsa_pkg::REG_SLOT_SIZE) begin
      prdata = bsa_pkg::DATA_W'(size_r);
    end else begin
      prdata = bsa_pkg::DATA_W'(cnt_r);
    end
  end

  // clamp register writes into their legal ranges
  always_comb begin
    wcnt  = pwdata[bsa_pkg::CNT_W-1:0];
    wsize = pwdata[bsa_pkg::SIZE_W-1:0];
    if (wcnt == '0) begin
      cnt_nxt = bsa_pkg::CNT_W'(1);
    end else if (wcnt > CNT_MAX) begin
      cnt_nxt = CNT_MAX;
    end else begin
      cnt_nxt = wcnt;
    end
    if (wsize == '0) begin
      size_nxt = bsa_pkg::SIZE_W'(1);
    end else if (wsize > bsa_pkg::SIZE_MAX) begin
      size_nxt = bsa_pkg::SIZE_MAX;
    end else begin
      size_nxt = wsize;
    end
    for (int i = 0; i < MAX_SLOTS; i++) begin
      rebuild_map[i] = bsa_pkg::CNT_W'(i) < cnt_nxt;
    end
  end

  // lowest free slot and release decode
  always_comb begin
    grant_hit  = 1'b0;
    grant_slot = '0;
    for (int i = MAX_SLOTS - 1; i >= 0; i--) begin
      if (free_r[i]) begin
        grant_hit  = 1'b1;
        grant_slot = bsa_pkg::SLOT_W'(i);
      end
    end
    for (int i = 0; i < MAX_SLOTS; i++) begin
      grant_mask[i] = grant_slot == bsa_pkg::SLOT_W'(i);
      rel_mask[i]   = {1'b0, a_item_r.slot_index} == bsa_pkg::CNT_W'(i);
    end
    rel_in_range = {1'b0, a_item_r.slot_index} < cnt_r;
    rel_busy     = (free_r & rel_mask) == '0;
    grant_ofs    = bsa_pkg::OFS_W'(grant_slot) * bsa_pkg::OFS_W'(size_r);
  end

  always_comb begin
    free_nxt = free_r;
    busy_nxt = busy_r;
    peak_nxt = peak_r;
    fail_nxt = fail_r;
    res_nxt  = '0;
    if (a_item_r.operation == bsa_pkg::OP_ACQUIRE) begin
      if (grant_hit) begin
        free_nxt            = free_r & ~grant_mask;
        busy_nxt            = busy_r + bsa_pkg::CNT_W'(1);
        if (busy_nxt > peak_r) begin
          peak_nxt = busy_nxt;
        end
        res_nxt.status      = bsa_pkg::ST_GRANTED;
        res_nxt.slot_number = grant_slot;
        res_nxt.byte_offset = grant_ofs;
      end else begin
        if (fail_r != bsa_pkg::FAIL_MAX) begin
          fail_nxt = fail_r + bsa_pkg::FAIL_W'(1);
        end
        res_nxt.status = bsa_pkg::ST_NONE_FREE;
      end
    end else begin
      if (!rel_in_range) begin
        res_nxt.status = bsa_pkg::ST_OUT_OF_RANGE;
      end else if (!rel_busy) begin
        res_nxt.status = bsa_pkg::ST_ALREADY_FREE;
      end else begin
        free_nxt       = free_r | rel_mask;
        busy_nxt       = busy_r - bsa_pkg::CNT_W'(1);
        res_nxt.status = bsa_pkg::ST_RELEASED;
      end
    end
    res_nxt.slots_in_use    = busy_nxt;
    res_nxt.peak_in_use     = peak_nxt;
    res_nxt.failed_acquires = fail_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r     <= CNT_MAX;
      size_r    <= bsa_pkg::SIZE_RESET;
      free_r    <= '1;
      busy_r    <= '0;
      peak_r    <= '0;
      fail_r    <= '0;
      a_vld_r   <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_fire) begin
        a_vld_r <= 1'b1;
      end else if (a_adv) begin
        a_vld_r <= 1'b0;
      end
      if (a_adv) begin
        out_vld_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_vld_r <= 1'b0;
      end
      if (cfg_wr && paddr[2] == bsa_pkg::REG_NUM_SLOTS) begin
        cnt_r  <= cnt_nxt;
        free_r <= rebuild_map;
        busy_r <= '0;
        peak_r <= '0;
        fail_r <= '0;
      end else if (a_adv) begin
        free_r <= free_nxt;
        busy_r <= busy_nxt;
        peak_r <= peak_nxt;
        fail_r <= fail_nxt;
      end
      if (cfg_wr && paddr[2] == bsa_pkg::REG_SLOT_SIZE) begin
        size_r <= size_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      a_item_r <= in_ch.payload;
    end
    if (a_adv) begin
      out_item_r <= res_nxt;
    end
  end

endmodule

`default_nettype wire
